>>> hw/rtl/firmware_chunk_framer_core_macros.svh
// ----------------------------------------------------------------------------
// Firmware chunk framer: assertion macros
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef FIRMWARE_CHUNK_FRAMER_CORE_MACROS_SVH
`define FIRMWARE_CHUNK_FRAMER_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define FCF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define FCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always live (reset behaviour)
`define FCF_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fcf_pkg.sv
// ----------------------------------------------------------------------------
// Firmware chunk framer: package
// Shared widths, constants, sequencer state and control struct.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int MAX_CHUNK_DEF = 50;
  localparam int BYTE_W        = 8;
  localparam int FILL_W        = 6;
  localparam int IMG_W         = 7;

  localparam logic [BYTE_W-1:0] LAST_FLAG   = 8'h80;
  localparam logic [IMG_W-1:0]  IMG_NUM_RST = 7'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_HDR,
    ST_LEN,
    ST_PAY,
    ST_CHK
  } state_t;

  // operand selection for the shared adder
  typedef enum logic [1:0] {
    ADD_FILL,
    ADD_SUM,
    ADD_IDX
  } add_sel_t;

  typedef struct packed {
    logic     take;
    logic     acc_en;
    logic     hdr_ld;
    logic     len_ld;
    logic     pay_ld;
    logic     chk_ld;
    add_sel_t add_sel;
  } ctrl_t;

endpackage

>>> hw/rtl/fcf_add.sv
// ----------------------------------------------------------------------------
// Firmware chunk framer: shared adder
// 8-bit wrapping adder used for fill count, checksum and read index.
// ----------------------------------------------------------------------------
module fcf_add (
  input  logic [fcf_pkg::BYTE_W-1:0] a,
  input  logic [fcf_pkg::BYTE_W-1:0] b,
  output logic [fcf_pkg::BYTE_W-1:0] y
);
  import fcf_pkg::*;

  assign y = a + b;

endmodule

>>> hw/rtl/fcf_mem.sv
// ----------------------------------------------------------------------------
// Firmware chunk framer: chunk store
// Single write port, single registered read port payload memory.
// ----------------------------------------------------------------------------
module fcf_mem #(
  parameter int DEPTH = fcf_pkg::MAX_CHUNK_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [fcf_pkg::BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [fcf_pkg::BYTE_W-1:0] rd_data
);
  import fcf_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/fcf_ctrl.sv
// ----------------------------------------------------------------------------
// Firmware chunk framer: sequencer
// Steps accumulation and packet drain, steering the shared adder.
// ----------------------------------------------------------------------------
module fcf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_free,
  input  logic           close,
  input  logic           pay_last,
  output logic           in_ready,
  output fcf_pkg::ctrl_t ctrl
);
  import fcf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = close ? ST_HDR : ST_IDLE;
      ST_HDR:  if (out_free) state_nxt = ST_LEN;
      ST_LEN:  if (out_free) state_nxt = ST_PAY;
      ST_PAY:  if (out_free && pay_last) state_nxt = ST_CHK;
      ST_CHK:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctrl         = '0;
    ctrl.add_sel = ADD_FILL;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.take = in_valid;
      end
      ST_ACC: begin
        ctrl.add_sel = ADD_SUM;
        ctrl.acc_en  = 1'b1;
      end
      ST_HDR:  ctrl.hdr_ld = out_free;
      ST_LEN:  ctrl.len_ld = out_free;
      ST_PAY: begin
        ctrl.add_sel = ADD_IDX;
        ctrl.pay_ld  = out_free;
      end
      ST_CHK:  ctrl.chk_ld = out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/firmware_chunk_framer_core.sv
// ----------------------------------------------------------------------------
// Firmware chunk framer
// Gathers image bytes into chunks and sends each as a framed packet.
// ----------------------------------------------------------------------------
// Input stream: one image byte per transfer in in_tdata, in_tlast on the
// image's last byte. Output stream: packet bytes (header, length minus one,
// payload, 8-bit checksum), out_tlast on the checksum byte.
// Each input byte has an accept cycle (fill count update through the shared
// adder) followed by an accumulate cycle (checksum through the same adder);
// in_tready is low in the accumulate cycle.
// When a byte fills the chunk or ends the image, the header is loaded after
// that byte's accumulate cycle, then one packet byte per cycle while
// out_tready is high: n + 3 bytes for an n-byte chunk, paced by the single
// output register. Input is held off until the checksum byte is loaded.
// A stalled receiver simply freezes the drain; the output register holds.
// Reset clears fill count, checksum and sequencer, sets image number to 1;
// the chunk store is not cleared and needs no clearing pass.
// cfg_wr_en writes the image number (bits 6..0 of cfg_wr_data); write only
// while idle.
// ----------------------------------------------------------------------------
module firmware_chunk_framer_core #(
  parameter int MAX_CHUNK = fcf_pkg::MAX_CHUNK_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [fcf_pkg::IMG_W-1:0]  cfg_wr_data,  // image_number
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fcf_pkg::BYTE_W-1:0] in_tdata,     // fw_byte
  input  logic                       in_tlast,     // image_end
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fcf_pkg::BYTE_W-1:0] out_tdata,    // out_byte
  output logic                       out_tlast     // packet_end
);
  import fcf_pkg::*;

  localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

  ctrl_t             ctrl;
  logic              out_free;
  logic              close;
  logic              pay_last;

  logic [IMG_W-1:0]  img_r;
  logic [BYTE_W-1:0] byte_r;
  logic              end_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic [BYTE_W-1:0] add_a, add_b, add_y;
  logic [BYTE_W-1:0] rd_data;

  assign out_free = !out_valid_r || out_tready;
  assign close    = end_r || (fill_r == FILL_W'(MAX_CHUNK));
  assign pay_last = (add_y[FILL_W-1:0] == fill_r);

  fcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .close    (close),
    .pay_last (pay_last),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  always_comb begin
    case (ctrl.add_sel)
      ADD_SUM: begin
        add_a = sum_r;
        add_b = byte_r;
      end
      ADD_IDX: begin
        add_a = BYTE_W'(idx_r);
        add_b = BYTE_W'(1);
      end
      default: begin
        add_a = BYTE_W'(fill_r);
        add_b = BYTE_W'(1);
      end
    endcase
  end

  fcf_add u_add (
    .a (add_a),
    .b (add_b),
    .y (add_y)
  );

  // read address runs one step ahead so payload can leave every cycle while the output is not stalled
  fcf_mem #(
    .DEPTH (MAX_CHUNK),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (ctrl.take),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (idx_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    idx_nxt  = idx_r;
    if (ctrl.take) fill_nxt = add_y[FILL_W-1:0];
    if (ctrl.acc_en) sum_nxt = add_y;
    if (ctrl.pay_ld) idx_nxt = pay_last ? '0 : add_y[FILL_W-1:0];
    if (ctrl.chk_ld) begin
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (ctrl.hdr_ld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = BYTE_W'(img_r) | (end_r ? LAST_FLAG : '0);
      out_last_nxt  = 1'b0;
    end else if (ctrl.len_ld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = BYTE_W'(fill_r - FILL_W'(1));
      out_last_nxt  = 1'b0;
    end else if (ctrl.pay_ld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rd_data;
      out_last_nxt  = 1'b0;
    end else if (ctrl.chk_ld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sum_r;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_r       <= IMG_NUM_RST;
      fill_r      <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) img_r <= cfg_wr_data;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/fcf_checker.sv
// ----------------------------------------------------------------------------
// Firmware chunk framer: port checker
// Watches the top-level ports and flags sequencing slips.
// ----------------------------------------------------------------------------
`include "firmware_chunk_framer_core_macros.svh"

module fcf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [fcf_pkg::BYTE_W-1:0] out_tdata,
  input logic                       out_tlast
);
  import fcf_pkg::*;

  // a taken byte is always followed by the accumulate cycle
  `FCF_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready straight after a transfer")

  // mid-packet bytes only appear while input is held off
  `FCF_ASSERT_NOW(a_no_input_mid_packet, clk, rst_n, out_tvalid && !out_tlast, !in_tready, "input open during packet drain")

  `FCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output changed")

  `FCF_ASSERT_ALWAYS(a_reset_state, clk, !rst_n, !out_tvalid && in_tready, "wrong state after reset")

endmodule

bind firmware_chunk_framer_core fcf_checker u_fcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
